@@ src/bfp_pkg.sv @@
// bfp_pkg: shared types and constants for the bond price from yield unit
// holds field widths, register indexes, controller states and the
// command/status structs between controller and datapath; no dependencies
`default_nettype none

package bfp_pkg;

	localparam int NOTIONAL_W = 32;
	localparam int RATE_W     = 24;
	localparam int PERIOD_W   = 8;
	localparam int YIELD_W    = 24;
	localparam int PRICE_W    = 56;
	localparam int AMT_W      = 48;  // coupon and face in Q.16
	localparam int Q32_W      = 33;  // unsigned Q1.32, 1.0 included
	localparam int ACC_W      = PRICE_W + 1;
	localparam int CFG_IDX_W  = 2;

	localparam int MAX_PERIODS_DEF     = 255;
	localparam int YIELD_FRAC_BITS_DEF = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_NOTIONAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODS  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_LOOP,
		S_FACE,
		S_DRAIN
	} bfp_state_t;

	typedef struct packed {
		logic load;       // accept a yield, start the divider
		logic pow_en;     // advance d^t
		logic term_en;    // push a term into the multiply pipe
		logic term_face;  // term amount is the face instead of the coupon
		logic finish;     // capture the saturated sum
	} bfp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic pipe_busy;
	} bfp_status_t;

endpackage

`default_nettype wire

@@ src/bond_price_from_yield_unit.sv @@
// bond_price_from_yield_unit: top level, configuration registers and the
// controller/datapath pair; uses bfp_pkg, bfp_ctrl, bfp_datapath, bfp_div
//
// Prices a plain fixed-coupon bond from a per-period yield. Pulse start with
// period_yield while busy is low; the result beat appears on bond_price with
// done high for exactly one cycle and cannot be held off, so the receiver
// must take it then. An item passes the one-bit-per-cycle divider for the
// discount factor, then one power multiplier step per period (period_count
// limited to MAX_PERIODS), the face term and a short drain of the term
// multiply/add pipe. One item is worked at a time; a new start is taken in
// the cycle the previous result shows.
// Registers notional_amount (0), coupon_rate (1) and period_count (2) are
// written over the cfg channel, which is always ready; write them only
// while busy is low. Other indexes are ignored.
`default_nettype none

module bond_price_from_yield_unit #(
	parameter int MAX_PERIODS     = bfp_pkg::MAX_PERIODS_DEF,
	parameter int YIELD_FRAC_BITS = bfp_pkg::YIELD_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [bfp_pkg::YIELD_W-1:0]    period_yield,
	output logic                                done,
	output logic [bfp_pkg::PRICE_W-1:0]         bond_price,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bfp_pkg::NOTIONAL_W-1:0] cfg_data
);
	import bfp_pkg::*;

	logic [NOTIONAL_W-1:0] notional_q;
	logic [RATE_W-1:0]     rate_q;
	logic [PERIOD_W-1:0]   periods_q;
	logic                  cfg_wr;
	logic                  accept;
	bfp_cmd_t              cmd;
	bfp_status_t           status;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notional_q <= '0;
			rate_q     <= '0;
			periods_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_NOTIONAL: notional_q <= cfg_data;
				CFG_RATE:     rate_q     <= cfg_data[RATE_W-1:0];
				CFG_PERIODS:  periods_q  <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bfp_ctrl #(
		.MAX_PERIODS(MAX_PERIODS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.period_count(periods_q),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done)
	);

	bfp_datapath #(
		.YIELD_FRAC_BITS(YIELD_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.period_yield   (period_yield),
		.notional_amount(notional_q),
		.coupon_rate    (rate_q),
		.bond_price     (bond_price)
	);

endmodule

`default_nettype wire

@@ src/bfp_div.sv @@
// bfp_div: restoring divider for the discount factor 2^(32+F) / (2^F + y)
// one quotient bit per cycle; uses bfp_pkg
`default_nettype none

module bfp_div #(
	parameter int FRAC_BITS = bfp_pkg::YIELD_FRAC_BITS_DEF,
	parameter int DW = ((FRAC_BITS > bfp_pkg::YIELD_W) ? FRAC_BITS : bfp_pkg::YIELD_W) + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic [DW-1:0]           den,
	output logic [bfp_pkg::Q32_W-1:0]    quot,
	output logic                         busy
);
	import bfp_pkg::*;

	localparam int CNT_W = $clog2(Q32_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q32_W - 1);
	localparam logic [DW:0] REM_INIT = (DW + 1)'(1) << FRAC_BITS;

	logic [DW-1:0]    den_q;
	logic [DW:0]      rem_q;
	logic [Q32_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic             ge;
	logic [DW:0]      diff;
	logic [DW:0]      kept;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = rem_q - {1'b0, den_q};
	assign kept = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP)
				busy_q <= 1'b0;
		end
	end

	// numerator is 2^F followed by 32 zero bits, so only a shift feeds in
	always_ff @(posedge clk) begin
		if (load) begin
			den_q  <= den;
			rem_q  <= REM_INIT;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {kept[DW-1:0], 1'b0};
			quot_q <= {quot_q[Q32_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign busy = busy_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= LAST_STEP))
		else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

@@ src/bfp_datapath.sv @@
// bfp_datapath: discount factor, power chain d^t, term multipliers and sum
// driven by bfp_cmd_t from the controller; uses bfp_pkg and bfp_div
`default_nettype none

module bfp_datapath #(
	parameter int YIELD_FRAC_BITS = bfp_pkg::YIELD_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bfp_pkg::bfp_cmd_t             cmd,
	output bfp_pkg::bfp_status_t               status,
	input  wire logic [bfp_pkg::YIELD_W-1:0]   period_yield,
	input  wire logic [bfp_pkg::NOTIONAL_W-1:0] notional_amount,
	input  wire logic [bfp_pkg::RATE_W-1:0]    coupon_rate,
	output logic [bfp_pkg::PRICE_W-1:0]        bond_price
);
	import bfp_pkg::*;

	localparam int DW = ((YIELD_FRAC_BITS > YIELD_W) ? YIELD_FRAC_BITS : YIELD_W) + 1;
	localparam logic [DW-1:0]    ONE_Y   = DW'(1) << YIELD_FRAC_BITS;
	localparam logic [Q32_W-1:0] ONE_Q32 = Q32_W'(1) << (Q32_W - 1);
	localparam int CPN_PROD_W = NOTIONAL_W + RATE_W;

	logic [DW-1:0]             den;
	logic [Q32_W-1:0]          d;
	logic                      div_busy;

	logic [CPN_PROD_W-1:0]     cpn_prod;
	logic [AMT_W-1:0]          coupon_q;
	logic [AMT_W-1:0]          face;
	logic [AMT_W-1:0]          amt;

	logic [Q32_W-1:0]          p_q;
	logic [2*Q32_W-1:0]        pow_prod;

	logic [32+Q32_W-1:0]       lo_prod;
	logic [16+Q32_W-1:0]       hi_prod;
	logic [31:0]               lo_s1;
	logic [AMT_W-1:0]          hi_s1;
	logic                      vld_s1;
	logic [AMT_W:0]            term_s2;
	logic                      vld_s2;
	logic [ACC_W-1:0]          acc_q;
	logic [PRICE_W-1:0]        price_q;

	assign den = ONE_Y + DW'(period_yield);

	bfp_div #(
		.FRAC_BITS(YIELD_FRAC_BITS),
		.DW       (DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (cmd.load),
		.den   (den),
		.quot  (d),
		.busy  (div_busy)
	);

	assign cpn_prod = CPN_PROD_W'(notional_amount) * CPN_PROD_W'(coupon_rate);
	assign face     = {notional_amount, 16'b0};
	assign amt      = cmd.term_face ? face : coupon_q;

	assign pow_prod = (2*Q32_W)'(p_q) * (2*Q32_W)'(d);
	// amount split at bit 32 so neither product is wider than 32 x 33
	assign lo_prod  = (32+Q32_W)'(amt[31:0]) * (32+Q32_W)'(p_q);
	assign hi_prod  = (16+Q32_W)'(amt[AMT_W-1:32]) * (16+Q32_W)'(p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.term_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coupon_q <= cpn_prod[CPN_PROD_W-1:8];
			p_q      <= ONE_Q32;
			acc_q    <= '0;
		end else begin
			if (cmd.pow_en)
				p_q <= pow_prod[2*Q32_W-2:Q32_W-1];
			if (vld_s2)
				acc_q <= acc_q + ACC_W'(term_s2);
		end
		lo_s1   <= lo_prod[63:32];
		hi_s1   <= hi_prod[AMT_W-1:0];
		term_s2 <= (AMT_W+1)'(hi_s1) + (AMT_W+1)'(lo_s1);
		if (cmd.finish)
			price_q <= acc_q[ACC_W-1] ? {PRICE_W{1'b1}} : acc_q[PRICE_W-1:0];
	end

	assign status.div_busy  = div_busy;
	assign status.pipe_busy = vld_s1 | vld_s2;
	assign bond_price       = price_q;

`ifndef SYNTHESIS
	a_pow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && p_q[Q32_W-1]) |-> (p_q[Q32_W-2:0] == '0))
		else $error("power of discount factor above one");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("term pipe out of order");
	a_no_term_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(vld_s1 || vld_s2 || cmd.term_en))
		else $error("sum captured with terms in flight");
`endif

endmodule

`default_nettype wire

@@ src/bfp_ctrl.sv @@
// bfp_ctrl: sequencer for one pricing run: divide, period loop, face term,
// drain and result strobe; talks to bfp_datapath through bfp_cmd_t/bfp_status_t
`default_nettype none

module bfp_ctrl #(
	parameter int MAX_PERIODS = bfp_pkg::MAX_PERIODS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bfp_pkg::PERIOD_W-1:0]  period_count,
	input  wire bfp_pkg::bfp_status_t          status,
	output bfp_pkg::bfp_cmd_t                  cmd,
	output logic                               busy,
	output logic                               done
);
	import bfp_pkg::*;

	localparam int CW = $clog2(MAX_PERIODS + 1);
	localparam int EW = (CW > PERIOD_W) ? CW : PERIOD_W;
	localparam logic [EW-1:0] MAX_EXT = EW'(MAX_PERIODS);

	bfp_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] m_q;
	logic [EW-1:0] m_ext;
	logic          cnt_clr, cnt_inc;
	logic          done_q;

	assign m_ext = (EW'(period_count) > MAX_EXT) ? MAX_EXT : EW'(period_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
			if (cnt_clr)
				cnt_q <= '0;
			else if (cnt_inc)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			m_q <= m_ext[CW-1:0];
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cnt_clr = 1'b0;
		cnt_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cnt_clr = 1'b1;
				if (!status.div_busy)
					state_d = S_LOOP;
			end
			S_LOOP: begin
				// p holds d^cnt: advance it, and sum the coupon term from t = 1 on
				cmd.pow_en  = cnt_q != m_q;
				cmd.term_en = cnt_q != '0;
				cnt_inc     = 1'b1;
				if (cnt_q == m_q)
					state_d = S_FACE;
			end
			S_FACE: begin
				cmd.term_en   = 1'b1;
				cmd.term_face = 1'b1;
				state_d       = S_DRAIN;
			end
			S_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOP) |-> (cnt_q <= m_q))
		else $error("period counter past maturity");
	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_DRAIN) && (state_q == S_IDLE))
		else $error("result strobe outside of drain");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one beat");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for bond_price_from_yield_unit, which prices each accepted yield
// against its own bit-exact model held in a small scoreboard class; depends on bfp_pkg and the rtl

module tb_top;
	import bfp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // index the block does not decode
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 120;
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_HEAVY  = 84;
	localparam int IDLE_LIGHT  = 31;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [YIELD_W-1:0]    period_yield;
	logic                  done;
	logic [PRICE_W-1:0]    bond_price;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [NOTIONAL_W-1:0] cfg_data;
	int                    idle_pct;

	class price_board;
		bit [NOTIONAL_W-1:0] notional;
		bit [RATE_W-1:0]     rate;
		bit [PERIOD_W-1:0]   periods;
		logic [PRICE_W-1:0]  expected_prices[$];
		int                  errors;

		function new();
			notional = '0;
			rate     = '0;
			periods  = '0;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOTIONAL_W-1:0] data);
			case (idx)
			CFG_NOTIONAL: notional = data;
			CFG_RATE:     rate = data[RATE_W-1:0];
			CFG_PERIODS:  periods = data[PERIOD_W-1:0];
			default:      ;
			endcase
		endfunction

		// present value: coupons discounted by d^t, face by d^M, saturating
		function logic [PRICE_W-1:0] price_for(logic [YIELD_W-1:0] y);
			bit [127:0] disc;
			bit [127:0] pw;
			bit [127:0] coupon;
			bit [127:0] face;
			bit [127:0] total;
			int         n;
			n = periods;
			if (n > MAX_PERIODS_DEF)
				n = MAX_PERIODS_DEF;
			disc = (128'd1 << (32 + YIELD_FRAC_BITS_DEF)) /
				((128'd1 << YIELD_FRAC_BITS_DEF) + 128'(y));
			coupon = (128'(notional) * 128'(rate)) >> 8;
			face   = 128'(notional) << 16;
			pw     = 128'd1 << 32;
			total  = '0;
			for (int t = 1; t <= n; t++) begin
				pw    = (pw * disc) >> 32;
				total = total + ((coupon * pw) >> 32);
			end
			total = total + ((face * pw) >> 32);
			if (total > ((128'd1 << PRICE_W) - 1))
				total = (128'd1 << PRICE_W) - 1;
			return total[PRICE_W-1:0];
		endfunction

		function void note_yield(logic [YIELD_W-1:0] y);
			expected_prices.push_back(price_for(y));
		endfunction

		function void check_price(logic [PRICE_W-1:0] actual);
			logic [PRICE_W-1:0] want;
			if (expected_prices.size() == 0) begin
				$error("bond_price: result 0x%0h with none expected", actual);
				errors++;
				return;
			end
			want = expected_prices.pop_front();
			if (actual !== want) begin
				$error("bond_price expected 0x%0h actual 0x%0h", want, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_prices.size();
		endfunction
	endclass

	price_board board = new();

	bond_price_from_yield_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.period_yield (period_yield),
		.done         (done),
		.bond_price   (bond_price),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// beats seen at the edge: register writes, accepted yields, result beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				board.note_yield(period_yield);
			if (done)
				board.check_price(bond_price);
		end
	end

	task automatic send_yield(input logic [YIELD_W-1:0] y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		period_yield <= y;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NOTIONAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// upper data bits are passed through on purpose, the block must drop them
	task automatic program_regs(input logic [31:0] n, input logic [31:0] r, input logic [31:0] p);
		write_reg(CFG_NOTIONAL, n);
		write_reg(CFG_RATE, r);
		write_reg(CFG_PERIODS, p);
		write_reg(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// wait out every expected result so the registers may be touched
	task automatic settle();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0 || busy);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic [YIELD_W-1:0] pick_yield();
		logic [YIELD_W-1:0] y;
		case ($urandom_range(7))
		0:       y = '0;
		1:       y = '1;
		2:       y = YIELD_W'($urandom_range(255));
		3:       y = ~YIELD_W'($urandom_range(255));
		default: y = YIELD_W'($urandom);
		endcase
		return y;
	endfunction

	initial begin
		logic [31:0] n;
		logic [31:0] p;
		int          base_pct;
		start        <= 1'b0;
		period_yield <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		idle_pct = IDLE_NONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: everything prices to zero
		send_yield('0);
		send_yield('1);
		settle();

		// largest bond, close to the top of the price range at zero yield
		program_regs('1, 32'hFF_FFFFFF, 32'hFFFF_FFFF);
		send_yield('0);
		send_yield(24'd1);
		send_yield('1);
		send_yield(24'h800000);
		settle();

		// zero periods gives back the face value
		program_regs(32'h1234_5678, 32'hAB_CDEF01, 32'hFFFF_FF00);
		send_yield('0);
		send_yield(24'h123456);
		settle();

		program_regs(32'd1000, 32'd838861, 32'd10);
		send_yield('0);
		send_yield(24'd1);
		send_yield('1);
		send_yield(24'h800000);
		send_yield(24'h0A3D71);
		settle();

		program_regs(32'hFFFF_FFFF, 32'd1, 32'd1);
		send_yield(24'h555555);
		send_yield(24'hAAAAAA);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(3))
			0:       n = '1;
			1:       n = $urandom_range(1000000);
			default: n = $urandom;
			endcase
			// long maturities only in a few phases to bound the run
			if (phase % 4 == 3)
				p = ($urandom & 32'hFFFF_FF00) | 32'd255;
			else if (phase == 5)
				p = $urandom & 32'hFFFF_FF00;
			else
				p = ($urandom & 32'hFFFF_FF00) | $urandom_range(40);
			program_regs(n, $urandom, p);
			case (phase % 4)
			1:       base_pct = IDLE_HEAVY;
			3:       base_pct = IDLE_LIGHT;
			default: base_pct = IDLE_NONE;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				idle_pct = ((i / 30) % 2 == 1) ? IDLE_NONE : base_pct;
				send_yield(pick_yield());
			end
			idle_pct = IDLE_NONE;
			settle();
		end

		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("** bond_price_from_yield_unit: PASSED **");
		else
			$display("** bond_price_from_yield_unit: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** bond_price_from_yield_unit: FAILED **");
		$finish;
	end

endmodule

@@ bond_price_from_yield_unit.f @@
src/bfp_pkg.sv
src/bfp_div.sv
src/bfp_datapath.sv
src/bfp_ctrl.sv
src/bond_price_from_yield_unit.sv
bench/tb_top.sv
